>>> src/midc_pkg.sv
package midc_pkg;

  // Width of one position, velocity or acceleration word
  localparam int VEL_W = 32;
  // Width of a limit or drag magnitude
  localparam int MAG_W = 31;
  // Width of the frame time step, unsigned Q0.16
  localparam int DT_BITS = 16;
  // Frame time after reset
  localparam logic [DT_BITS-1:0] FRAME_TIME_RST = 16'd1092;

endpackage

>>> src/midc_if.sv
// Input channel: one axis of one object
interface midc_item_if;
  logic                             valid;
  logic                             ready;
  logic                             rotational;
  logic signed [midc_pkg::VEL_W-1:0] position;
  logic signed [midc_pkg::VEL_W-1:0] velocity;
  logic signed [midc_pkg::VEL_W-1:0] acceleration;
  logic        [midc_pkg::MAG_W-1:0] drag;
  logic        [midc_pkg::MAG_W-1:0] max_velocity;

  modport source (output valid, rotational, position, velocity, acceleration, drag,
                  max_velocity, input ready);
  modport sink   (input valid, rotational, position, velocity, acceleration, drag,
                  max_velocity, output ready);
endinterface

// Output channel: new position and velocity for the axis
interface midc_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [midc_pkg::VEL_W-1:0] new_position;
  logic signed [midc_pkg::VEL_W-1:0] new_velocity;

  modport source (output valid, new_position, new_velocity, input ready);
  modport sink   (input valid, new_position, new_velocity, output ready);
endinterface

// Configuration write channel: frame time step
interface midc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [midc_pkg::DT_BITS-1:0]       frame_time;

  modport source (output valid, frame_time, input ready);
  modport sink   (input valid, frame_time, output ready);
endinterface

>>> src/midc_mul_dt.sv
// Registered x * dt, scaled back by the dt fraction with floor rounding
module midc_mul_dt #(
  parameter int X_W = midc_pkg::VEL_W
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [X_W-1:0]             x,
  input  logic        [midc_pkg::DT_BITS-1:0] dt,
  output logic signed [X_W-1:0]             q
);

  localparam int P_W = X_W + midc_pkg::DT_BITS + 1;

  logic signed [P_W-1:0] prod;
  logic signed [P_W-1:0] prod_next;

  // Form the full product; dt is treated as a non-negative fraction
  always_comb begin
    prod_next = P_W'(x) * P_W'($signed({1'b0, dt}));
  end

  // Hold the product while the stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

  // Dropping the fraction bits of a two's complement word rounds toward minus infinity;
  // |x * dt| / 2^16 never exceeds |x|, so the result fits the operand width
  assign q = prod[midc_pkg::DT_BITS +: X_W];

endmodule

>>> src/motion_integrate_drag_clamp_top.sv
// Per-axis motion integrator with drag and velocity limit, Q16.16.
//
// Channels: item (sink) takes one axis of one object: rotational flag,
// position, velocity, acceleration, drag and velocity limit. result (source)
// gives the new position and new velocity for that item, in the same order.
// cfg (sink) writes the frame time step dt (unsigned Q0.16); it is always
// ready and should only be written while no item is in flight.
//
// Pipeline: seven register stages (pre-clamp, dt multiply, target, limit clamp,
// midpoint, second dt multiply, add and saturate); the first loads at the edge
// that accepts the item, and result.valid is the valid bit of the last stage.
// Throughput: one item per cycle. Each stage advances when it is empty or the
// stage after it advances, so bubbles close up and a full pipeline keeps
// taking items for as long as result is taken.
// Stall: while result.ready is low the output register holds its item and the
// stages behind it fill; item.ready falls once every stage holds an item.
// Nothing is lost or repeated.
// Reset (rst, synchronous): all stages empty, dt back to 1092 (about 1/60 s).
module motion_integrate_drag_clamp_top (
  input  logic          clk,
  input  logic          rst,
  midc_item_if.sink     item,
  midc_result_if.source result,
  midc_cfg_if.sink      cfg
);

  localparam int VW = midc_pkg::VEL_W;
  localparam int MW = midc_pkg::MAG_W;
  localparam int TW = VW + 1;   // target and midpoint width
  localparam int NS = 7;        // register stages

  localparam logic signed [VW:0] S_MAX = (VW+1)'({2'b00, {(VW-1){1'b1}}});
  localparam logic signed [VW:0] S_MIN = (VW+1)'({2'b11, {(VW-1){1'b0}}});

  // Saturate a one-bit-wider value to the word range
  function automatic logic signed [VW-1:0] sat_w(input logic signed [VW:0] v);
    logic signed [VW-1:0] r;
    begin
      if (v > S_MAX) r = S_MAX[VW-1:0];
      else if (v < S_MIN) r = S_MIN[VW-1:0];
      else r = v[VW-1:0];
      return r;
    end
  endfunction

  logic [midc_pkg::DT_BITS-1:0] frame_time;
  logic [NS:1] vld;
  logic [NS:1] en;

  // Stage registers
  logic signed [VW-1:0] vel1, op1, pos1;
  logic                 use_acc1;
  logic        [MW-1:0] lim1;
  logic signed [VW-1:0] vel2, pos2, q2;
  logic                 use_acc2;
  logic        [MW-1:0] lim2;
  logic signed [TW-1:0] tgt3;
  logic signed [VW-1:0] vel3, pos3;
  logic        [MW-1:0] lim3;
  logic signed [TW-1:0] tgt4;
  logic signed [VW-1:0] vel4, pos4;
  logic signed [TW-1:0] mid5, tgt5;
  logic signed [VW-1:0] pos5;
  logic signed [TW-1:0] q6, tgt6;
  logic signed [VW-1:0] pos6;
  logic signed [VW-1:0] npos7, nvel7;

  // Next values
  logic signed [VW-1:0] vel1_next, op1_next;
  logic signed [TW-1:0] tgt3_next, tgt4_next, mid5_next;
  logic signed [VW-1:0] npos7_next, nvel7_next;

  // Stage enables: advance when empty or when the next stage advances
  always_comb begin
    en[NS] = !vld[NS] || result.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign item.ready = en[1];
  assign cfg.ready  = 1'b1;

  // Configuration register and stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= midc_pkg::FRAME_TIME_RST;
      vld        <= '0;
    end else begin
      if (cfg.valid) begin
        frame_time <= cfg.frame_time;
      end
      if (en[1]) begin
        vld[1] <= item.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: pre-clamp a linear axis, pick the multiplicand
  always_comb begin
    logic signed [VW:0] v;
    logic signed [VW:0] l;
    v = (VW+1)'(item.velocity);
    l = (VW+1)'($signed({2'b00, item.max_velocity}));
    if (!item.rotational && v > l) v = l;
    if (!item.rotational && v < -l) v = -l;
    vel1_next = v[VW-1:0];
    op1_next  = (item.acceleration != '0) ? item.acceleration
                                          : $signed({1'b0, item.drag});
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vel1     <= vel1_next;
      op1      <= op1_next;
      pos1     <= item.position;
      use_acc1 <= (item.acceleration != '0);
      lim1     <= item.max_velocity;
    end
  end

  // Stage 2: acceleration or drag times dt
  midc_mul_dt #(.X_W(VW)) u_mul_acc (
    .clk (clk),
    .en  (en[2]),
    .x   (op1),
    .dt  (frame_time),
    .q   (q2)
  );

  always_ff @(posedge clk) begin
    if (en[2]) begin
      vel2     <= vel1;
      pos2     <= pos1;
      use_acc2 <= use_acc1;
      lim2     <= lim1;
    end
  end

  // Stage 3: target velocity; drag pulls toward zero and stops there
  always_comb begin
    logic signed [VW+1:0] v;
    logic signed [VW+1:0] d;
    logic signed [VW+1:0] sub;
    logic signed [VW+1:0] add;
    v   = (VW+2)'(vel2);
    d   = (VW+2)'(q2);
    sub = v - d;
    add = v + d;
    if (use_acc2) tgt3_next = add[TW-1:0];
    else if (sub > 0) tgt3_next = sub[TW-1:0];
    else if (add < 0) tgt3_next = add[TW-1:0];
    else tgt3_next = '0;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      tgt3 <= tgt3_next;
      vel3 <= vel2;
      pos3 <= pos2;
      lim3 <= lim2;
    end
  end

  // Stage 4: clamp the target when a limit is set
  always_comb begin
    logic signed [TW-1:0] l;
    l = $signed({2'b00, lim3});
    tgt4_next = tgt3;
    if (lim3 != '0) begin
      if (tgt3 > l) tgt4_next = l;
      else if (tgt3 < -l) tgt4_next = -l;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      tgt4 <= tgt4_next;
      vel4 <= vel3;
      pos4 <= pos3;
    end
  end

  // Stage 5: midpoint of incoming and target velocity, floor of the half step
  always_comb begin
    logic signed [TW:0] diff;
    logic signed [TW:0] m;
    diff = (TW+1)'(tgt4) - (TW+1)'(vel4);
    m    = (TW+1)'(vel4) + (diff >>> 1);
    mid5_next = m[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mid5 <= mid5_next;
      tgt5 <= tgt4;
      pos5 <= pos4;
    end
  end

  // Stage 6: midpoint velocity times dt
  midc_mul_dt #(.X_W(TW)) u_mul_mid (
    .clk (clk),
    .en  (en[6]),
    .x   (mid5),
    .dt  (frame_time),
    .q   (q6)
  );

  always_ff @(posedge clk) begin
    if (en[6]) begin
      tgt6 <= tgt5;
      pos6 <= pos5;
    end
  end

  // Stage 7: advance position and saturate both results
  always_comb begin
    logic signed [TW:0] s;
    s = (TW+1)'(pos6) + (TW+1)'(q6);
    if (s > (TW+1)'(S_MAX)) npos7_next = S_MAX[VW-1:0];
    else if (s < (TW+1)'(S_MIN)) npos7_next = S_MIN[VW-1:0];
    else npos7_next = s[VW-1:0];
    nvel7_next = sat_w(tgt6);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      npos7 <= npos7_next;
      nvel7 <= nvel7_next;
    end
  end

  assign result.valid        = vld[NS];
  assign result.new_position = npos7;
  assign result.new_velocity = nvel7;

endmodule
